// ===== src/adfr_pkg.sv =====
// ----------------------------------------------------------------------------
// adfr_pkg
// shared constants, codes and types of the api frame deframer
// ----------------------------------------------------------------------------
package adfr_pkg;

  localparam int BufferDepth = 256;
  localparam int AddrW       = $clog2(BufferDepth);
  localparam logic [15:0] LenLimit = 16'(BufferDepth - 10);
  localparam logic [7:0]  ChecksumGood  = 8'hFF;
  localparam logic [7:0]  StartDelimRst = 8'h7E;

  localparam logic [1:0] OpRxByte  = 2'd0;
  localparam logic [1:0] OpRead    = 2'd1;
  localparam logic [1:0] OpRelease = 2'd2;

  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvAccept  = 3'd1;
  localparam logic [2:0] EvTooLong = 3'd2;
  localparam logic [2:0] EvBadCsum = 3'd3;
  localparam logic [2:0] EvOverrun = 3'd4;

  localparam int OutDataW = 64;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } adfr_wr_t;

  typedef struct packed {
    logic        frame_ready;
    logic [15:0] frame_length;
    logic [2:0]  event_res;
    logic [15:0] error_total;
    logic [15:0] overrun_total;
  } adfr_stat_t;

endpackage

// ===== src/api_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// api_frame_deframer
// length-prefixed frame receiver with 8-bit checksum and indexed payload buffer
//
//   port group   dir  beat contents
//   s_axis       in   tuser opcode, tdata byte_value / read_index
//   m_axis       out  tdata read_data .. overrun_total, one beat per input beat
//   apb          in   start_delimiter at byte address 0
//
// one beat per cycle sustained unless m_axis stalls; each result is registered
// in the read of the payload buffer and then in the output stage
// reset clears parser state, counters and start_delimiter (0x7e); the buffer
// is not cleared, no sweep is run
// a stalled output holds up to two results before s_axis_tready drops
// ----------------------------------------------------------------------------
module api_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // byte_value, read_index
  input  logic [1:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // read_data, frame_ready, frame_length,
                                     // event_res, error_total, overrun_total
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import adfr_pkg::*;

  logic        in_acc;
  logic [7:0]  byte_value;
  logic [7:0]  read_index;
  logic [7:0]  start_delim_q;
  adfr_wr_t    wr;
  adfr_stat_t  stat;
  logic        rd_hit;
  logic [7:0]  rdata;
  logic        s1_valid_q, s1_valid_d;
  adfr_stat_t  s1_stat_q;
  logic        s1_rd_q;
  logic        out_free;
  logic        s1_adv;
  logic        out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q;
  logic [7:0]  rd_mux;

  assign byte_value = s_axis_tdata[7:0];
  assign read_index = s_axis_tdata[15:8];

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'h0, start_delim_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_delim_q <= StartDelimRst;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      start_delim_q <= pwdata[7:0];
    end
  end

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s1_adv        = s1_valid_q && out_free;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign rd_hit = (s_axis_tuser == OpRead) && (32'(read_index) < BufferDepth);

  adfr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .opcode_i      (s_axis_tuser),
    .byte_value_i  (byte_value),
    .start_delim_i (start_delim_q),
    .wr_o          (wr),
    .stat_o        (stat)
  );

  adfr_buf u_buf (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .re_i    (in_acc && rd_hit),
    .raddr_i (AddrW'(read_index)),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_stat_q <= stat;
      s1_rd_q   <= rd_hit;
    end
  end

  assign rd_mux = s1_rd_q ? rdata : 8'h00;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= {4'h0, s1_stat_q.overrun_total, s1_stat_q.error_total,
                     s1_stat_q.event_res, s1_stat_q.frame_length,
                     s1_stat_q.frame_ready, rd_mux};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== src/adfr_buf.sv =====
// ----------------------------------------------------------------------------
// adfr_buf
// payload buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module adfr_buf (
  input  logic                    clk_i,
  input  adfr_pkg::adfr_wr_t      wr_i,
  input  logic                    re_i,
  input  logic [adfr_pkg::AddrW-1:0] raddr_i,
  output logic [7:0]              rdata_o
);
  import adfr_pkg::*;

  logic [7:0] mem_q [BufferDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/adfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// adfr_ctrl
// frame parser: phase, length, running sum, pending flag and counters
// ----------------------------------------------------------------------------
module adfr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [1:0]           opcode_i,
  input  logic [7:0]           byte_value_i,
  input  logic [7:0]           start_delim_i,
  output adfr_pkg::adfr_wr_t   wr_o,
  output adfr_pkg::adfr_stat_t stat_o
);
  import adfr_pkg::*;

  localparam logic [2:0] PhHunt   = 3'd0;
  localparam logic [2:0] PhStart  = 3'd1;
  localparam logic [2:0] PhLenMsb = 3'd2;
  localparam logic [2:0] PhPay    = 3'd3;
  localparam logic [2:0] PhCsum   = 3'd4;

  logic [2:0]       phase_q, phase_d;
  logic [15:0]      len_q, len_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [7:0]       sum_q, sum_d;
  logic             pend_q, pend_d;
  logic [15:0]      err_q, err_d;
  logic [15:0]      ovr_q, ovr_d;
  logic [2:0]       ev;
  logic [AddrW:0]   idx_inc;
  logic [15:0]      len_new;
  logic [7:0]       csum;
  logic             fail;

  assign idx_inc = {1'b0, idx_q} + 1'b1;
  assign len_new = {len_q[15:8], byte_value_i};
  assign csum    = byte_value_i + sum_q;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    pend_d  = pend_q;
    err_d   = err_q;
    ovr_d   = ovr_q;
    ev      = EvNone;
    fail    = 1'b0;
    wr_o.we   = 1'b0;
    wr_o.addr = idx_q;
    wr_o.data = byte_value_i;
    unique case (opcode_i)
      OpRxByte: begin
        unique case (phase_q)
          PhHunt: begin
            if (byte_value_i == start_delim_i) begin
              phase_d = PhStart;
            end
          end
          PhStart: begin
            if (pend_q) begin
              ovr_d = ovr_q + 16'd1;
              ev    = EvOverrun;
              fail  = 1'b1;
            end else begin
              len_d   = {byte_value_i, 8'h00};
              phase_d = PhLenMsb;
            end
          end
          PhLenMsb: begin
            len_d   = len_new;
            phase_d = PhPay;
            idx_d   = '0;
            sum_d   = '0;
            if (len_new > LenLimit) begin
              ev   = EvTooLong;
              fail = 1'b1;
            end
          end
          PhPay: begin
            wr_o.we = 1'b1;
            sum_d   = sum_q + byte_value_i;
            idx_d   = idx_inc[AddrW-1:0];
            if (16'(idx_inc) > LenLimit) begin
              ev   = EvTooLong;
              fail = 1'b1;
            end else if (16'(idx_inc) >= len_q) begin
              phase_d = PhCsum;
            end
          end
          PhCsum: begin
            if (csum != ChecksumGood) begin
              ev   = EvBadCsum;
              fail = 1'b1;
            end else begin
              ev      = EvAccept;
              pend_d  = 1'b1;
              phase_d = PhHunt;
              idx_d   = '0;
              sum_d   = '0;
            end
          end
          default: begin
            phase_d = PhHunt;
            idx_d   = '0;
            sum_d   = '0;
          end
        endcase
        if (fail) begin
          err_d   = err_q + 16'd1;
          phase_d = PhHunt;
          idx_d   = '0;
          sum_d   = '0;
        end
      end
      OpRelease: pend_d = 1'b0;
      default: ;
    endcase
    wr_o.we = wr_o.we & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      len_q   <= '0;
      idx_q   <= '0;
      sum_q   <= '0;
      pend_q  <= 1'b0;
      err_q   <= '0;
      ovr_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      sum_q   <= sum_d;
      pend_q  <= pend_d;
      err_q   <= err_d;
      ovr_q   <= ovr_d;
    end
  end

  assign stat_o.frame_ready   = pend_d;
  assign stat_o.frame_length  = len_d;
  assign stat_o.event_res     = ev;
  assign stat_o.error_total   = err_d;
  assign stat_o.overrun_total = ovr_d;

endmodule
